### design/srit_pkg.sv
`default_nettype none

package srit_pkg;

    // bytes of a name that take part in ordering
    localparam int NAME_BYTES = 9;

    // one stored contact record
    typedef struct packed {
        logic        kind;
        logic [63:0] name_head;
        logic [7:0]  name_tail;
        logic [63:0] number_head;
        logic [7:0]  number_tail;
        logic [1:0]  carrier;
    } rec_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    // strcmp-style "a sorts strictly before b" over the nine name bytes
    function automatic logic name_less(input logic [63:0] ah, input logic [7:0] at,
                                       input logic [63:0] bh, input logic [7:0] bt);
        logic [8*NAME_BYTES-1:0] a;
        logic [8*NAME_BYTES-1:0] b;
        logic [7:0]              ab;
        logic [7:0]              bb;
        logic                    done;
        logic                    less;
        a    = {ah, at};
        b    = {bh, bt};
        done = 1'b0;
        less = 1'b0;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            ab = a[8*NAME_BYTES-1-8*i -: 8];
            bb = b[8*NAME_BYTES-1-8*i -: 8];
            if (!done)
            begin
                if (ab != bb)
                begin
                    less = (ab < bb);
                    done = 1'b1;
                end
                else if (ab == 8'd0)
                begin
                    done = 1'b1;
                end
            end
        end
        return less;
    endfunction

endpackage

`default_nettype wire

### design/srit_store.sv
`default_nettype none

// Record memory: one write port, one read port, registered read data
module srit_store #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic [ADDR_W-1:0]  wr_addr,
    input  wire srit_pkg::rec_t     wr_data,
    input  wire logic [ADDR_W-1:0]  rd_addr,
    output srit_pkg::rec_t          rd_data
);

    srit_pkg::rec_t mem [DEPTH];
    srit_pkg::rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### design/sorted_record_insert_table.sv
`default_nettype none

// Sorted contact table.
// Command port: a record is taken at a clock edge with start high and busy
// low. The record is inserted after every stored record whose name is equal
// or smaller (unsigned bytes, comparison stops at the first zero byte), and
// the whole table is then listed, one beat per entry, in ascending order.
// Each beat is on the result ports for one cycle with out_valid high; the
// receiver has no way to stall, so beats go out back to back. last_entry
// marks the final beat; dropped is set on every beat when the table was
// full and the record was discarded.
// The first beat is registered from the first walk step after the
// accepting edge. Each record takes one walk over the record memory,
// one entry per cycle, reading entry k while writing the shifted entry
// k-1 back, so the single read port and single write port set the rate;
// busy stays high for the walk, so a new record waits for the listing.
// Reset empties the table at once (the entry count clears; the memory
// needs no clearing pass) and returns the block to idle.
module sorted_record_insert_table #(
    parameter int CAPACITY = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output      logic        busy,
    input  wire logic        line_kind,
    input  wire logic [63:0] name_head,
    input  wire logic [7:0]  name_tail,
    input  wire logic [63:0] number_head,
    input  wire logic [7:0]  number_tail,
    input  wire logic [1:0]  carrier,
    output      logic        out_valid,
    output      logic        out_kind,
    output      logic [63:0] out_name_head,
    output      logic [7:0]  out_name_tail,
    output      logic [63:0] out_number_head,
    output      logic [7:0]  out_number_tail,
    output      logic [1:0]  out_carrier,
    output      logic [4:0]  position,
    output      logic        last_entry,
    output      logic        dropped
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // control state
    srit_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0] last_reg;
    logic             drop_reg;
    logic             placed_reg, placed_next;
    logic             out_valid_reg;

    // payload
    srit_pkg::rec_t   new_reg;
    srit_pkg::rec_t   carry_reg, carry_next;
    srit_pkg::rec_t   out_rec_reg;
    logic [IDX_W-1:0] out_pos_reg;
    logic             out_last_reg;
    logic             out_drop_reg;

    // memory port signals
    logic             wr_en;
    srit_pkg::rec_t   wr_data;
    logic [IDX_W-1:0] rd_addr;
    srit_pkg::rec_t   rd_data;

    logic             accept;
    logic             full;
    logic             at_last;
    logic             emit;
    srit_pkg::rec_t   in_rec;

    assign accept  = start && (state_reg == srit_pkg::ST_IDLE);
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign at_last = (step_reg == last_reg);

    // home lines always carry operator code zero
    always_comb
    begin
        in_rec.kind        = line_kind;
        in_rec.name_head   = name_head;
        in_rec.name_tail   = name_tail;
        in_rec.number_head = number_head;
        in_rec.number_tail = number_tail;
        in_rec.carrier     = line_kind ? carrier : 2'd0;
    end

    srit_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (step_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // walk: unless dropped, place at first larger name or end, ripple carry
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        placed_next = placed_reg;
        carry_next  = carry_reg;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_data     = rd_data;
        emit        = 1'b0;
        case (state_reg)
            srit_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next  = srit_pkg::ST_WALK;
                    step_next   = '0;
                    placed_next = 1'b0;
                end
            end
            srit_pkg::ST_WALK:
            begin
                emit = 1'b1;
                if (drop_reg)
                begin
                    wr_data = rd_data;
                end
                else if (placed_reg)
                begin
                    wr_en      = 1'b1;
                    wr_data    = carry_reg;
                    carry_next = rd_data;
                end
                else if (at_last ||
                         srit_pkg::name_less(new_reg.name_head, new_reg.name_tail,
                                             rd_data.name_head, rd_data.name_tail))
                begin
                    wr_en       = 1'b1;
                    wr_data     = new_reg;
                    placed_next = 1'b1;
                    carry_next  = rd_data;
                end
                if (at_last)
                begin
                    state_next = srit_pkg::ST_IDLE;
                    rd_addr    = '0;
                end
                else
                begin
                    step_next = step_reg + IDX_W'(1);
                    rd_addr   = step_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = srit_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srit_pkg::ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            last_reg      <= '0;
            drop_reg      <= 1'b0;
            placed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            placed_reg    <= placed_next;
            out_valid_reg <= emit;
            if (accept)
            begin
                drop_reg <= full;
                if (full)
                begin
                    last_reg <= IDX_W'(count_reg - CNT_W'(1));
                end
                else
                begin
                    last_reg  <= IDX_W'(count_reg);
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        if (accept)
        begin
            new_reg <= in_rec;
        end
        if (emit)
        begin
            out_rec_reg  <= wr_data;
            out_pos_reg  <= step_reg;
            out_last_reg <= at_last;
            out_drop_reg <= drop_reg;
        end
    end

    assign busy            = (state_reg != srit_pkg::ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign out_kind        = out_rec_reg.kind;
    assign out_name_head   = out_rec_reg.name_head;
    assign out_name_tail   = out_rec_reg.name_tail;
    assign out_number_head = out_rec_reg.number_head;
    assign out_number_tail = out_rec_reg.number_tail;
    assign out_carrier     = out_rec_reg.carrier;
    assign position        = 5'(out_pos_reg);
    assign last_entry      = out_last_reg;
    assign dropped         = out_drop_reg;

endmodule

`default_nettype wire
